// File: hw/rtl/cnis_pkg.sv
package cnis_pkg;

    // defaults for the top-level parameters
    localparam int BODY_COUNT_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_SOLVE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // multiplier operand selection
    localparam logic [2:0] MUL_DOT    = 3'd0;
    localparam logic [2:0] MUL_GAIN   = 3'd1;
    localparam logic [2:0] MUL_JVEC   = 3'd2;
    localparam logic [2:0] MUL_MASS_A = 3'd3;
    localparam logic [2:0] MUL_MASS_B = 3'd4;

    // body memory write source
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_BODY = 2'd1;
    localparam logic [1:0] WR_A    = 2'd2;
    localparam logic [1:0] WR_B    = 2'd3;

    // one body table entry
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] m;
    } body_t;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       rd_sel_b;
        logic       cap_read;
        logic       cap_va;
        logic       cap_dv;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       sum_en;
        logic       err_en;
        logic       jnew_en;
        logic [1:0] wr_kind;
        logic       out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       applied_nz;
    } status_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // fixed-point product, round half up, saturated
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input int frac);
        logic signed [63:0] p;
        p = a * b;
        p = p + (64'sd1 <<< (frac - 1));
        return sat32(p >>> frac);
    endfunction

endpackage

// File: hw/rtl/cnis_dpath.sv
module cnis_dpath #(
    parameter int BODY_COUNT = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          req_type,
    input  logic signed [10:0]  body_a,
    input  logic signed [10:0]  body_b,
    input  logic signed [31:0]  vec_x,
    input  logic signed [31:0]  vec_y,
    input  logic signed [31:0]  vec_z,
    input  logic signed [31:0]  target_speed,
    input  logic signed [31:0]  inv_stiffness,
    input  logic [30:0]         impulse_in,
    input  logic signed [31:0]  inv_mass_in,
    input  cnis_pkg::cmd_t      cmd,
    output cnis_pkg::status_t   status,
    output logic [30:0]         impulse_out,
    output logic signed [31:0]  applied_impulse,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y,
    output logic signed [31:0]  vel_z,
    output logic signed [31:0]  inv_mass_out
);
    import cnis_pkg::*;

    localparam int AW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;

    // index in range of the table
    function automatic logic idx_ok(input logic signed [10:0] i);
        return !i[10] && (32'(i[9:0]) < BODY_COUNT);
    endfunction

    // latched request
    logic [1:0]         req_reg;
    logic               a_ok_reg;
    logic               b_ok_reg;
    logic               same_reg;
    logic [AW-1:0]      addr_a_reg;
    logic [AW-1:0]      addr_b_reg;
    logic signed [31:0] n_reg [3];
    logic signed [31:0] target_reg;
    logic signed [31:0] invk_reg;
    logic [30:0]        jold_reg;
    logic signed [31:0] imass_reg;

    // body memory
    body_t              mem [BODY_COUNT];
    body_t              rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    body_t              wr_data;
    logic signed [31:0] rd_v [3];

    // solve datapath
    logic signed [31:0] va_reg [3];
    logic signed [31:0] vb_reg [3];
    logic signed [31:0] dv_reg [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] im_a_reg;
    logic signed [31:0] im_b_reg;
    logic signed [31:0] vrel_reg;
    logic signed [31:0] err_reg;
    logic [30:0]        jnew_reg;
    logic signed [31:0] applied_reg;
    body_t              rres_reg;

    logic signed [31:0] ma [3];
    logic signed [31:0] mb [3];
    logic signed [31:0] mr [3];
    logic signed [31:0] va_new [3];
    logic signed [31:0] vb_new [3];
    logic signed [31:0] vb_cur [3];
    logic signed [31:0] vb_sel [3];
    logic signed [63:0] jsum;
    logic [30:0]        jnew_next;
    logic signed [31:0] applied_next;
    logic               apply_a;
    logic               apply_b;

    // output register
    logic [30:0]        impulse_out_reg;
    logic signed [31:0] applied_out_reg;
    body_t              res_body_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg    <= req_type;
            a_ok_reg   <= idx_ok(body_a);
            b_ok_reg   <= idx_ok(body_b);
            same_reg   <= (body_a == body_b);
            addr_a_reg <= AW'(body_a[9:0]);
            addr_b_reg <= AW'(body_b[9:0]);
            n_reg[0]   <= vec_x;
            n_reg[1]   <= vec_y;
            n_reg[2]   <= vec_z;
            target_reg <= target_speed;
            invk_reg   <= inv_stiffness;
            jold_reg   <= impulse_in;
            imass_reg  <= inv_mass_in;
        end
    end

    assign apply_a = a_ok_reg && (im_a_reg > 0);
    assign apply_b = b_ok_reg && (im_b_reg > 0);

    // per-lane update values
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            va_new[i] = sat32(64'(va_reg[i]) - 64'(d_reg[i]));
            vb_cur[i] = same_reg ? va_reg[i] : vb_reg[i];
            vb_new[i] = sat32(64'(vb_cur[i]) + 64'(d_reg[i]));
            vb_sel[i] = b_ok_reg ? rd_v[i] : 32'sd0;
        end
    end

    assign rd_v[0] = rd_data_reg.x;
    assign rd_v[1] = rd_data_reg.y;
    assign rd_v[2] = rd_data_reg.z;

    // memory write source
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = addr_a_reg;
        wr_data = '0;
        case (cmd.wr_kind)
            WR_BODY:
            begin
                mem_we  = a_ok_reg;
                wr_data = '{x: n_reg[0], y: n_reg[1], z: n_reg[2], m: imass_reg};
            end
            WR_A:
            begin
                mem_we  = apply_a;
                wr_data = '{x: va_new[0], y: va_new[1], z: va_new[2], m: im_a_reg};
            end
            WR_B:
            begin
                mem_we  = apply_b;
                wr_addr = addr_b_reg;
                wr_data = '{x: vb_new[0], y: vb_new[1], z: vb_new[2], m: im_b_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign rd_addr = cmd.rd_sel_b ? addr_b_reg : addr_a_reg;

    // body memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // multiplier operands
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma[i] = 32'sd0;
            mb[i] = 32'sd0;
            case (cmd.mul_sel)
                MUL_DOT:
                begin
                    ma[i] = dv_reg[i];
                    mb[i] = n_reg[i];
                end
                MUL_GAIN:
                begin
                    if (i == 0)
                    begin
                        ma[i] = err_reg;
                        mb[i] = invk_reg;
                    end
                end
                MUL_JVEC:
                begin
                    ma[i] = applied_reg;
                    mb[i] = n_reg[i];
                end
                MUL_MASS_A:
                begin
                    ma[i] = im_a_reg;
                    mb[i] = p_reg[i];
                end
                MUL_MASS_B:
                begin
                    ma[i] = im_b_reg;
                    mb[i] = p_reg[i];
                end
                default:
                begin
                    ma[i] = 32'sd0;
                end
            endcase
            mr[i] = mulq(ma[i], mb[i], FRAC_BITS);
        end
    end

    // impulse clamp
    always_comb
    begin
        jsum = $signed(64'(jold_reg)) + 64'(p_reg[0]);
        if (jsum < 0)
            jnew_next = '0;
        else if (jsum > 64'sh0000_0000_7FFF_FFFF)
            jnew_next = '1;
        else
            jnew_next = jsum[30:0];
        applied_next = $signed({1'b0, jnew_next}) - $signed({1'b0, jold_reg});
    end

    // solve and read registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_va)
        begin
            for (int i = 0; i < 3; i++)
                va_reg[i] <= a_ok_reg ? rd_v[i] : 32'sd0;
            im_a_reg <= rd_data_reg.m;
        end
        else if (cmd.wr_kind == WR_A && apply_a)
        begin
            for (int i = 0; i < 3; i++)
                va_reg[i] <= va_new[i];
        end
        if (cmd.cap_dv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vb_reg[i] <= vb_sel[i];
                dv_reg[i] <= sat32(64'(vb_sel[i]) - 64'(va_reg[i]));
            end
            im_b_reg <= rd_data_reg.m;
        end
        if (cmd.mul_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cmd.mul_sel == MUL_MASS_A || cmd.mul_sel == MUL_MASS_B)
                    d_reg[i] <= mr[i];
                else
                    p_reg[i] <= mr[i];
            end
        end
        if (cmd.sum_en)
            vrel_reg <= sat32(64'(p_reg[0]) + 64'(p_reg[1]) + 64'(p_reg[2]));
        if (cmd.err_en)
            err_reg <= sat32(64'(target_reg) - 64'(vrel_reg));
        if (cmd.jnew_en)
        begin
            jnew_reg    <= jnew_next;
            applied_reg <= applied_next;
        end
        if (cmd.cap_read)
            rres_reg <= a_ok_reg ? rd_data_reg : '0;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (req_reg)
                REQ_SOLVE:
                begin
                    impulse_out_reg <= jnew_reg;
                    applied_out_reg <= applied_reg;
                    res_body_reg    <= '0;
                end
                REQ_READ:
                begin
                    impulse_out_reg <= '0;
                    applied_out_reg <= '0;
                    res_body_reg    <= rres_reg;
                end
                default:
                begin
                    impulse_out_reg <= '0;
                    applied_out_reg <= '0;
                    res_body_reg    <= '0;
                end
            endcase
        end
    end

    assign status.req        = req_reg;
    assign status.applied_nz = (applied_reg != 32'sd0);

    assign impulse_out     = impulse_out_reg;
    assign applied_impulse = applied_out_reg;
    assign vel_x           = res_body_reg.x;
    assign vel_y           = res_body_reg.y;
    assign vel_z           = res_body_reg.z;
    assign inv_mass_out    = res_body_reg.m;

`ifndef SYNTH
    // body B update uses the mass product of the cycle before
    a_upd_b_after_mass: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_kind == WR_B) |-> $past(cmd.mul_en && cmd.mul_sel == MUL_MASS_B))
        else $error("body B update without preceding mass product");

    // table writes only reach entries inside the table
    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(wr_addr) < BODY_COUNT))
        else $error("body table write outside the table");

    // gain product follows the error step
    a_gain_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_en && cmd.mul_sel == MUL_GAIN) |-> $past(cmd.err_en))
        else $error("gain product without preceding error step");
`endif

endmodule

// File: hw/rtl/cnis_ctrl.sv
module cnis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  cnis_pkg::status_t status,
    output cnis_pkg::cmd_t    cmd
);
    import cnis_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDA   = 4'd1;
    localparam logic [3:0] ST_RDCAP = 4'd2;
    localparam logic [3:0] ST_RDB   = 4'd3;
    localparam logic [3:0] ST_DIFF  = 4'd4;
    localparam logic [3:0] ST_DOT   = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_ERR   = 4'd7;
    localparam logic [3:0] ST_GAIN  = 4'd8;
    localparam logic [3:0] ST_JNEW  = 4'd9;
    localparam logic [3:0] ST_JVEC  = 4'd10;
    localparam logic [3:0] ST_MASSA = 4'd11;
    localparam logic [3:0] ST_UPDA  = 4'd12;
    localparam logic [3:0] ST_MASSB = 4'd13;
    localparam logic [3:0] ST_UPDB  = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    // sequencer
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_RDA;
                end
            end
            ST_RDA:
            begin
                case (status.req)
                    REQ_WRITE:
                    begin
                        cmd.wr_kind = WR_BODY;
                        state_next  = ST_DONE;
                    end
                    REQ_READ:  state_next = ST_RDCAP;
                    REQ_SOLVE: state_next = ST_RDB;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_RDCAP:
            begin
                cmd.cap_read = 1'b1;
                state_next   = ST_DONE;
            end
            ST_RDB:
            begin
                cmd.rd_sel_b = 1'b1;
                cmd.cap_va   = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.cap_dv = 1'b1;
                state_next = ST_DOT;
            end
            ST_DOT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DOT;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
                state_next  = ST_JNEW;
            end
            ST_JNEW:
            begin
                cmd.jnew_en = 1'b1;
                state_next  = ST_JVEC;
            end
            ST_JVEC:
            begin
                // no body update when the impulse did not change
                if (status.applied_nz)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_JVEC;
                    state_next  = ST_MASSA;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MASSA:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MASS_A;
                state_next  = ST_UPDA;
            end
            ST_UPDA:
            begin
                cmd.wr_kind = WR_A;
                state_next  = ST_MASSB;
            end
            ST_MASSB:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MASS_B;
                state_next  = ST_UPDB;
            end
            ST_UPDB:
            begin
                cmd.wr_kind = WR_B;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.out_load)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_RDA))
        else $error("accepted request did not start the sequence");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the done step");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (res_valid && state_reg == ST_IDLE))
        else $error("result load did not present a result");
`endif

endmodule

// File: hw/rtl/contact_normal_impulse_solver_core.sv
// Contact normal impulse solver with a body table of BODY_COUNT entries
// (velocity x, y, z and inverse mass, Q-format with FRAC_BITS fraction bits).
// One request is in work at a time; each gives one result transfer. A contact
// solve runs the body updates only when the impulse changes. The step order
// is set by the body memory with one read and one write port (two reads, then
// one update per body) and by one shared three-lane multiply unit that runs the
// dot product, the gain, the impulse vector and the two mass scalings one after
// another. A new request is taken while the previous result still waits in the
// output register. Table entries are undefined until written; there is no clear.
module contact_normal_impulse_solver_core #(
    parameter int BODY_COUNT = cnis_pkg::BODY_COUNT_DEF,
    parameter int FRAC_BITS  = cnis_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         req_type,
    input  logic signed [10:0] body_a,
    input  logic signed [10:0] body_b,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [31:0] target_speed,
    input  logic signed [31:0] inv_stiffness,
    input  logic [30:0]        impulse_in,
    input  logic signed [31:0] inv_mass_in,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [30:0]        impulse_out,
    output logic signed [31:0] applied_impulse,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] inv_mass_out
);
    import cnis_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    cnis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // body memory and arithmetic
    cnis_dpath #(
        .BODY_COUNT (BODY_COUNT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_type        (req_type),
        .body_a          (body_a),
        .body_b          (body_b),
        .vec_x           (vec_x),
        .vec_y           (vec_y),
        .vec_z           (vec_z),
        .target_speed    (target_speed),
        .inv_stiffness   (inv_stiffness),
        .impulse_in      (impulse_in),
        .inv_mass_in     (inv_mass_in),
        .cmd             (cmd),
        .status          (status),
        .impulse_out     (impulse_out),
        .applied_impulse (applied_impulse),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .inv_mass_out    (inv_mass_out)
    );

endmodule

// File: verif/tb_contact_normal_impulse_solver_core.sv
module tb_contact_normal_impulse_solver_core;

    import cnis_pkg::*;

    localparam int NBODY       = BODY_COUNT_DEF;
    localparam int QBITS       = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    // one request transfer
    typedef struct {
        logic [1:0]         kind;
        logic signed [10:0] a;
        logic signed [10:0] b;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] target;
        logic signed [31:0] invk;
        logic [30:0]        imp;
        logic signed [31:0] mass;
    } contact_req_t;

    // one result transfer
    typedef struct {
        logic [30:0]        imp;
        logic signed [31:0] applied;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] m;
    } body_result_t;

    // saturate to 32 bits signed
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // fixed-point product, rounded half up, saturated
    function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< (QBITS - 1));
        return clamp32(p >>> QBITS);
    endfunction

    // expected-result tracking and body table prediction
    class contact_scoreboard;
        logic signed [31:0] tab_x [NBODY];
        logic signed [31:0] tab_y [NBODY];
        logic signed [31:0] tab_z [NBODY];
        logic signed [31:0] tab_m [NBODY];
        body_result_t       expected_results[$];
        int                 errors;

        function new();
            errors = 0;
            foreach (tab_x[i])
            begin
                tab_x[i] = 0;
                tab_y[i] = 0;
                tab_z[i] = 0;
                tab_m[i] = 0;
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function int slot(logic signed [10:0] i);
            return (i < 0) ? -1 : int'(i);
        endfunction

        // push an impulse into one body, skipped for static bodies
        function void push_body(int idx, logic signed [31:0] jx, logic signed [31:0] jy,
                                logic signed [31:0] jz, bit add);
            logic signed [31:0] im;
            logic signed [31:0] dx, dy, dz;
            if (idx < 0)
                return;
            im = tab_m[idx];
            if (im <= 0)
                return;
            dx = qmul(im, jx);
            dy = qmul(im, jy);
            dz = qmul(im, jz);
            if (add)
            begin
                tab_x[idx] = clamp32(longint'(tab_x[idx]) + dx);
                tab_y[idx] = clamp32(longint'(tab_y[idx]) + dy);
                tab_z[idx] = clamp32(longint'(tab_z[idx]) + dz);
            end
            else
            begin
                tab_x[idx] = clamp32(longint'(tab_x[idx]) - dx);
                tab_y[idx] = clamp32(longint'(tab_y[idx]) - dy);
                tab_z[idx] = clamp32(longint'(tab_z[idx]) - dz);
            end
        endfunction

        // accepted request: update tables, queue the expected result
        function void note_request(contact_req_t r);
            body_result_t       e;
            int                 ia, ib;
            logic signed [31:0] vax, vay, vaz, vbx, vby, vbz, vrel, err;
            logic signed [31:0] jx, jy, jz;
            longint             jnew, dlt;
            e = '{default: 0};
            ia = slot(r.a);
            ib = slot(r.b);
            if (r.kind == REQ_WRITE && ia >= 0)
            begin
                tab_x[ia] = r.x;
                tab_y[ia] = r.y;
                tab_z[ia] = r.z;
                tab_m[ia] = r.mass;
            end
            else if (r.kind == REQ_READ && ia >= 0)
            begin
                e.vx = tab_x[ia];
                e.vy = tab_y[ia];
                e.vz = tab_z[ia];
                e.m  = tab_m[ia];
            end
            else if (r.kind == REQ_SOLVE)
            begin
                vax = (ia >= 0) ? tab_x[ia] : 0;
                vay = (ia >= 0) ? tab_y[ia] : 0;
                vaz = (ia >= 0) ? tab_z[ia] : 0;
                vbx = (ib >= 0) ? tab_x[ib] : 0;
                vby = (ib >= 0) ? tab_y[ib] : 0;
                vbz = (ib >= 0) ? tab_z[ib] : 0;
                vrel = clamp32(longint'(qmul(clamp32(longint'(vbx) - vax), r.x))
                             + longint'(qmul(clamp32(longint'(vby) - vay), r.y))
                             + longint'(qmul(clamp32(longint'(vbz) - vaz), r.z)));
                err = clamp32(longint'(r.target) - vrel);
                jnew = longint'(r.imp) + longint'(qmul(err, r.invk));
                if (jnew < 0)
                    jnew = 0;
                if (jnew > 64'sh7FFF_FFFF)
                    jnew = 64'sh7FFF_FFFF;
                dlt = jnew - longint'(r.imp);
                e.imp = jnew[30:0];
                e.applied = dlt[31:0];
                // body a first, so a contact of a body with itself sees the update
                if (dlt != 0)
                begin
                    jx = qmul(e.applied, r.x);
                    jy = qmul(e.applied, r.y);
                    jz = qmul(e.applied, r.z);
                    push_body(ia, jx, jy, jz, 1'b0);
                    push_body(ib, jx, jy, jz, 1'b1);
                end
            end
            expected_results.push_back(e);
        endfunction

        task report(string what, longint got, longint exp);
            $display("mismatch %s: got %0d expected %0d", what, got, exp);
            errors++;
        endtask

        // accepted result: compare with the oldest expectation
        task check_result(body_result_t g);
            body_result_t e;
            if (expected_results.size() == 0)
            begin
                report("unexpected result transfer", 1, 0);
                return;
            end
            e = expected_results.pop_front();
            if (g.imp !== e.imp)
                report("impulse_out", g.imp, e.imp);
            if (g.applied !== e.applied)
                report("applied_impulse", g.applied, e.applied);
            if (g.vx !== e.vx)
                report("vel_x", g.vx, e.vx);
            if (g.vy !== e.vy)
                report("vel_y", g.vy, e.vy);
            if (g.vz !== e.vz)
                report("vel_z", g.vz, e.vz);
            if (g.m !== e.m)
                report("inv_mass_out", g.m, e.m);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         req_type;
    logic signed [10:0] body_a;
    logic signed [10:0] body_b;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] target_speed;
    logic signed [31:0] inv_stiffness;
    logic [30:0]        impulse_in;
    logic signed [31:0] inv_mass_in;
    logic               res_valid;
    logic               res_stall;
    logic [30:0]        impulse_out;
    logic signed [31:0] applied_impulse;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] inv_mass_out;

    contact_scoreboard sb;
    bit                written [NBODY];
    int                send_pct;
    int                stall_pct;
    int                hold_left;
    int                cycle_count;

    contact_normal_impulse_solver_core i_dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: take transfers, stall at random or for a long hold-off
    initial
    begin
        body_result_t got;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                got.imp     = impulse_out;
                got.applied = applied_impulse;
                got.vx      = vel_x;
                got.vy      = vel_y;
                got.vz      = vel_z;
                got.m       = inv_mass_out;
                sb.check_result(got);
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one request and wait for its transfer
    task send_item(contact_req_t r);
        while ($urandom_range(99) < send_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_type      <= r.kind;
        body_a        <= r.a;
        body_b        <= r.b;
        vec_x         <= r.x;
        vec_y         <= r.y;
        vec_z         <= r.z;
        target_speed  <= r.target;
        inv_stiffness <= r.invk;
        impulse_in    <= r.imp;
        inv_mass_in   <= r.mass;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        sb.note_request(r);
        if (r.kind == REQ_WRITE && r.a >= 0)
            written[r.a] = 1'b1;
    endtask

    // stop offering and wait until every result is in
    task drain();
        req_valid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic contact_req_t make_req(logic [1:0] k, int a, int b,
                                              logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [31:0] z, logic signed [31:0] t,
                                              logic signed [31:0] g, logic [30:0] j,
                                              logic signed [31:0] m);
        contact_req_t r;
        r.kind = k;
        r.a = a[10:0];
        r.b = b[10:0];
        r.x = x;
        r.y = y;
        r.z = z;
        r.target = t;
        r.invk = g;
        r.imp = j;
        r.mass = m;
        return r;
    endfunction

    // mostly moderate values, sometimes full range and extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom();
            default: return int'($urandom_range(524288)) - 262144;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_normal();
        if ($urandom_range(9) == 0)
            return pick_value();
        return int'($urandom_range(131072)) - 65536;
    endfunction

    function automatic int pick_body();
        case ($urandom_range(9))
            0: return ($urandom_range(3) == 0) ? -int'($urandom_range(1, 1024)) : -1;
            1, 2: return $urandom_range(NBODY - 1);
            default: return $urandom_range(15);
        endcase
    endfunction

    // random request; a body not yet written is written instead of read or solved
    function automatic contact_req_t random_req();
        contact_req_t       r;
        int                 a, b, sel;
        logic signed [31:0] m;
        logic [30:0]        j;
        sel = $urandom_range(9);
        a = pick_body();
        b = pick_body();
        case ($urandom_range(4))
            0: m = 0;
            1: m = -int'($urandom_range(1, 32'h7FFF_FFFF));
            default: m = $urandom_range(1, 131072);
        endcase
        j = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(262144));
        r = make_req(REQ_SOLVE, a, b, pick_normal(), pick_normal(), pick_normal(),
                     pick_value(), pick_value(), j, m);
        if (sel < 2)
            r.kind = REQ_WRITE;
        else if (sel < 4)
            r.kind = REQ_READ;
        if (r.kind != REQ_WRITE)
        begin
            if (a >= 0 && !written[a])
            begin
                r.kind = REQ_WRITE;
                r.x = pick_value();
            end
            else if (r.kind == REQ_SOLVE && b >= 0 && !written[b])
            begin
                r.kind = REQ_WRITE;
                r.a = r.b;
            end
        end
        return r;
    endfunction

    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    // main sequence
    initial
    begin
        contact_req_t dir[$];
        int           phase_send [4] = '{0, 52, 0, 32};
        int           phase_stall[4] = '{0, 0, 52, 32};
        sb = new();
        send_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = REQ_WRITE;
        body_a = 0;
        body_b = 0;
        vec_x = 0;
        vec_y = 0;
        vec_z = 0;
        target_speed = 0;
        inv_stiffness = 0;
        impulse_in = 0;
        inv_mass_in = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, absent and static bodies, shared body, no change
        dir.push_back(make_req(REQ_WRITE, 0, 0, QMAX, QMIN, 0, 0, 0, 0, ONE));
        dir.push_back(make_req(REQ_WRITE, 1, 0, QMIN, QMAX, -1, 0, 0, 0, QMAX));
        dir.push_back(make_req(REQ_WRITE, 1023, 0, ONE, -ONE, 5, 0, 0, 0, 0));
        dir.push_back(make_req(REQ_WRITE, 2, 0, 3, 4, 5, 0, 0, 0, QMIN));
        dir.push_back(make_req(REQ_WRITE, -1, 0, 7, 7, 7, 0, 0, 0, ONE));
        dir.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_req(REQ_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_req(REQ_READ, -1024, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_req(REQ_SOLVE, 0, 1, ONE, 0, 0, QMAX, QMAX, 31'h7FFF_FFFF, 0));
        dir.push_back(make_req(REQ_SOLVE, 0, 1, QMAX, QMIN, QMAX, QMIN, QMAX, 31'h7FFF_FFFF, 0));
        dir.push_back(make_req(REQ_SOLVE, -1, 0, 0, ONE, 0, ONE, ONE, 0, 0));
        dir.push_back(make_req(REQ_SOLVE, 1, -1, 0, 0, -ONE, -ONE, ONE, 100, 0));
        dir.push_back(make_req(REQ_SOLVE, -1, -1, ONE, ONE, ONE, ONE, ONE, 5, 0));
        dir.push_back(make_req(REQ_SOLVE, 1, 1, ONE, ONE, 0, ONE, 2 * ONE, 0, 0));
        dir.push_back(make_req(REQ_SOLVE, 0, 1, ONE, 0, 0, ONE, 0, 1234, 0));
        dir.push_back(make_req(REQ_SOLVE, 2, 1023, ONE, ONE, ONE, 3 * ONE, ONE, 0, 0));
        dir.push_back(make_req(REQ_SOLVE, 1023, 0, -ONE, 0, ONE, ONE, ONE, 0, 0));
        dir.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_req(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_req(REQ_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (dir[i])
            send_item(dir[i]);
        drain();

        // random phases with different idle and stall mixes
        for (int p = 0; p < 4; p++)
        begin
            send_pct = phase_send[p];
            stall_pct = phase_stall[p];
            if (p == 0)
                hold_left = 300;
            for (int n = 0; n < 350; n++)
            begin
                if (p == 1 && n == 175)
                    drain();
                send_item(random_req());
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cnis_pkg.sv
hw/rtl/cnis_dpath.sv
hw/rtl/cnis_ctrl.sv
hw/rtl/contact_normal_impulse_solver_core.sv
verif/tb_contact_normal_impulse_solver_core.sv
